/* src/trq_pkg.sv */
// ----------------------------------------------------------------------------
// Task run queue scheduler package
// Shared types, codes and constants for the run-list task scheduler.
// ----------------------------------------------------------------------------
package trq_pkg;

   localparam int MAX_TASKS_DEF = 16;
   localparam int SLOT_COUNT    = 16;
   localparam int SLOT_W        = 4;
   localparam int CNT_W         = 5;

   localparam logic [CNT_W-1:0] CNT_SAT       = 5'd16;
   localparam logic [7:0]       QUANTUM_RESET = 8'd10;

   // Request action codes.
   localparam logic [3:0] ACT_ADD         = 4'd0;
   localparam logic [3:0] ACT_REMOVE      = 4'd1;
   localparam logic [3:0] ACT_TICK        = 4'd2;
   localparam logic [3:0] ACT_YIELD       = 4'd3;
   localparam logic [3:0] ACT_BLOCK       = 4'd4;
   localparam logic [3:0] ACT_UNBLOCK     = 4'd5;
   localparam logic [3:0] ACT_SLEEP       = 4'd6;
   localparam logic [3:0] ACT_SET_RUNNING = 4'd7;
   localparam logic [3:0] ACT_START       = 4'd8;

   // Scheduling policies.
   localparam logic [1:0] MODE_COOP = 2'd0;
   localparam logic [1:0] MODE_RR   = 2'd1;
   localparam logic [1:0] MODE_PRIO = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_POLICY       = 2'd0;
   localparam logic [1:0] CSR_IDLE_SLOT    = 2'd1;
   localparam logic [1:0] CSR_IDLE_PRESENT = 2'd2;
   localparam logic [1:0] CSR_QUANTUM      = 2'd3;

   typedef enum logic [2:0] {
      ST_FREE     = 3'd0,
      ST_READY    = 3'd1,
      ST_RUNNING  = 3'd2,
      ST_BLOCKED  = 3'd3,
      ST_SLEEPING = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] chan;
      logic [31:0] wake;
      logic [7:0]  quant;
   } attr_type;

   typedef struct packed {
      logic prio;
      logic chan;
      logic wake;
      logic quant;
   } attr_we_type;

   typedef struct packed {
      logic              we;
      logic [SLOT_W-1:0] addr;
      attr_we_type       fld;
      attr_type          data;
   } attr_wr_type;

endpackage

/* src/trq_list_ram.sv */
// ----------------------------------------------------------------------------
// Run list memory
// Ordered list of task slots, one write port and one registered read port.
// ----------------------------------------------------------------------------
module trq_list_ram #(
   parameter int DEPTH = trq_pkg::MAX_TASKS_DEF
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [$clog2(DEPTH)-1:0]    waddr,
   input  logic [trq_pkg::SLOT_W-1:0]  wdata,
   input  logic [$clog2(DEPTH)-1:0]    raddr,
   output logic [trq_pkg::SLOT_W-1:0]  rdata
);
   import trq_pkg::*;

   logic [SLOT_W-1:0] mem_ff [DEPTH];
   logic [SLOT_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/trq_attr_ram.sv */
// ----------------------------------------------------------------------------
// Slot attribute memory
// Priority, wait channel, wake time and quantum per slot, field write enables.
// ----------------------------------------------------------------------------
module trq_attr_ram (
   input  logic                       clock,
   input  trq_pkg::attr_wr_type       wr,
   input  logic [trq_pkg::SLOT_W-1:0] raddr,
   output trq_pkg::attr_type          rdata
);
   import trq_pkg::*;

   attr_type mem_ff [SLOT_COUNT];
   attr_type rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         if (wr.fld.prio) begin
            mem_ff[wr.addr].prio <= wr.data.prio;
         end
         if (wr.fld.chan) begin
            mem_ff[wr.addr].chan <= wr.data.chan;
         end
         if (wr.fld.wake) begin
            mem_ff[wr.addr].wake <= wr.data.wake;
         end
         if (wr.fld.quant) begin
            mem_ff[wr.addr].quant <= wr.data.quant;
         end
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* src/task_run_queue_scheduler.sv */
// ----------------------------------------------------------------------------
// Task run queue scheduler
// Run-list scheduler with round robin and priority selection over slots.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; one result follows
// on the rsp_ ports for a single cycle with rsp_valid, and it cannot be held
// off. Add, set_running, unknown actions, and a yield, block or sleep that
// has nothing to do pass from the execute state straight to the result
// state. Tick, yield, block, sleep, unblock, start and remove walk the run
// list through the list and attribute memories at one entry per cycle
// behind the s1 and s2 read registers; unblock, start, remove and a
// cooperative tick skip the selection state. A tick that spends a quantum
// adds a quantum read and a decrement state; a remove adds a closing read
// state, and a read and a write state per entry moved up behind the removed one.
module task_run_queue_scheduler #(
   parameter int MAX_TASKS = trq_pkg::MAX_TASKS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [3:0]                 req_action,
   input  logic [trq_pkg::SLOT_W-1:0] req_task_slot,
   input  logic [7:0]                 req_task_priority,
   input  logic [15:0]                req_wait_channel_id,
   input  logic [31:0]                req_sleep_ticks,
   input  logic                       req_run_enable,
   output logic                       rsp_valid,
   output logic [trq_pkg::SLOT_W-1:0] rsp_current_slot,
   output logic                       rsp_current_valid,
   output logic                       rsp_switched,
   output logic [31:0]                rsp_tick_total,
   output logic [31:0]                rsp_switch_total,
   output logic [31:0]                rsp_idle_switch_total,
   output logic [trq_pkg::CNT_W-1:0]  rsp_runnable_total,
   output logic [trq_pkg::CNT_W-1:0]  rsp_blocked_total,
   output logic [trq_pkg::CNT_W-1:0]  rsp_sleeping_total,
   output logic                       rsp_can_sleep_now,
   output logic                       rsp_running_flag,
   input  logic                       csr_we,
   input  logic [1:0]                 csr_addr,
   input  logic [7:0]                 csr_wdata
);
   import trq_pkg::*;

   localparam int IW  = $clog2(MAX_TASKS);
   localparam int LW  = $clog2(MAX_TASKS + 1);
   localparam int CAP = (MAX_TASKS < SLOT_COUNT) ? MAX_TASKS : SLOT_COUNT;
   localparam logic [LW-1:0] CAP_L = LW'(CAP);

   typedef enum logic [3:0] {
      S_IDLE, S_EXEC, S_SCAN, S_POST, S_QREAD, S_QDEC, S_SCHED,
      S_SH_RD, S_SH_WR, S_RESP
   } state_type;

   state_type state_ff;

   // Configuration.
   logic [1:0]        mode_ff;
   logic [SLOT_W-1:0] idle_slot_ff;
   logic              idle_present_ff;
   logic [7:0]        quantum_ff;

   // Captured request.
   logic [3:0]        act_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [7:0]        pri_ff;
   logic [15:0]       chan_ff;
   logic [31:0]       sleep_ff;
   logic              run_en_ff;

   // Scheduler state.
   logic [LW-1:0]     len_ff;
   status_type        status_ff [SLOT_COUNT];
   logic [SLOT_W-1:0] cur_ff;
   logic              cur_v_ff;
   logic [31:0]       tick_ff;
   logic [31:0]       sw_cnt_ff;
   logic [31:0]       idle_cnt_ff;
   logic [CNT_W-1:0]  runnable_ff;
   logic [CNT_W-1:0]  blocked_ff;
   logic [CNT_W-1:0]  sleeping_ff;
   logic              active_ff;
   logic              sw_ff;

   // List walk.
   logic [LW-1:0]     rd_idx_ff;
   logic              s1_v_ff;
   logic [IW-1:0]     s1_idx_ff;
   logic              s2_v_ff;
   logic [IW-1:0]     s2_idx_ff;
   logic [SLOT_W-1:0] s2_slot_ff;
   logic [SLOT_W-1:0] key_ff;
   logic              excl_ff;
   logic              found_ff;
   logic [IW-1:0]     pos_ff;
   logic [CNT_W-1:0]  run_cnt_ff;
   logic              aft_v_ff;
   logic [SLOT_W-1:0] aft_slot_ff;
   logic [7:0]        aft_pri_ff;
   logic              bef_v_ff;
   logic [SLOT_W-1:0] bef_slot_ff;
   logic [7:0]        bef_pri_ff;
   logic [LW-1:0]     j_ff;

   // Result registers.
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_cur_ff;
   logic              rsp_cur_v_ff;
   logic              rsp_sw_ff;
   logic [31:0]       rsp_tick_ff;
   logic [31:0]       rsp_swc_ff;
   logic [31:0]       rsp_idlec_ff;
   logic [CNT_W-1:0]  rsp_run_ff;
   logic [CNT_W-1:0]  rsp_blk_ff;
   logic [CNT_W-1:0]  rsp_slp_ff;
   logic              rsp_cs_ff;
   logic              rsp_act_ff;

   // Memory ports.
   logic              list_we;
   logic [IW-1:0]     list_waddr;
   logic [SLOT_W-1:0] list_wdata;
   logic [IW-1:0]     list_raddr;
   logic [SLOT_W-1:0] list_rdata;
   attr_wr_type       attr_wr;
   logic [SLOT_W-1:0] attr_raddr;
   attr_type          attr_rdata;

   // Combinational helpers.
   logic              is_prio;
   logic              idle_ok;
   logic [SLOT_W-1:0] add_slot;
   logic              add_ok;
   logic [LW-1:0]     j_plus;
   status_type        e_st;
   logic              e_woke;
   logic              e_unb;
   status_type        e_eff;
   logic              e_key;
   logic              e_ready;
   logic              e_run;
   logic              take_aft;
   logic              take_bef;
   logic              pick_v;
   logic [SLOT_W-1:0] pick_slot;
   logic [7:0]        q_dec;
   logic              quantum_cond;
   logic              other_ready;
   logic              can_sleep;

   trq_list_ram #(.DEPTH(MAX_TASKS)) u_list (
      .clock (clock),
      .we    (list_we),
      .waddr (list_waddr),
      .wdata (list_wdata),
      .raddr (list_raddr),
      .rdata (list_rdata)
   );

   trq_attr_ram u_attr (
      .clock (clock),
      .wr    (attr_wr),
      .raddr (attr_raddr),
      .rdata (attr_rdata)
   );

   assign is_prio  = (mode_ff == MODE_PRIO);
   assign idle_ok  = idle_present_ff && (status_ff[idle_slot_ff] != ST_FREE);
   assign add_slot = (act_ff == ACT_START) ? idle_slot_ff : slot_ff;
   assign add_ok   = (status_ff[add_slot] == ST_FREE) && (len_ff < CAP_L);
   assign j_plus   = j_ff + LW'(1);
   assign q_dec    = (attr_rdata.quant != 8'd0) ? attr_rdata.quant - 8'd1 : 8'd0;
   assign quantum_cond = cur_v_ff && (status_ff[cur_ff] == ST_RUNNING) &&
                         !(idle_present_ff && (cur_ff == idle_slot_ff));

   // Per-entry evaluation at the end of the walk pipeline.
   always_comb begin
      e_st     = status_ff[s2_slot_ff];
      e_woke   = (act_ff == ACT_TICK) && (e_st == ST_SLEEPING) &&
                 (attr_rdata.wake <= tick_ff);
      e_unb    = (act_ff == ACT_UNBLOCK) && (e_st == ST_BLOCKED) &&
                 (attr_rdata.chan == chan_ff);
      e_eff    = e_woke ? ST_READY : e_st;
      e_key    = excl_ff && (s2_slot_ff == key_ff);
      e_ready  = (e_eff == ST_READY) && !e_key;
      e_run    = (e_eff == ST_READY) || (e_eff == ST_RUNNING);
      take_aft = e_ready && found_ff &&
                 (!aft_v_ff || (is_prio && (attr_rdata.prio > aft_pri_ff)));
      take_bef = e_ready && !found_ff &&
                 (!bef_v_ff || (is_prio && (attr_rdata.prio > bef_pri_ff)));
   end

   // Entries after the current one come first in scan order; an earlier entry
   // only wins in priority mode when its priority is strictly higher.
   always_comb begin
      pick_v    = 1'b1;
      pick_slot = idle_slot_ff;
      if (aft_v_ff && (!bef_v_ff || !is_prio || (aft_pri_ff >= bef_pri_ff))) begin
         pick_slot = aft_slot_ff;
      end else if (bef_v_ff) begin
         pick_slot = bef_slot_ff;
      end else begin
         pick_v = idle_ok;
      end
   end

   always_comb begin
      other_ready = 1'b0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
         if ((SLOT_W'(s) != cur_ff) && (status_ff[s] == ST_READY)) begin
            other_ready = 1'b1;
         end
      end
      can_sleep = active_ff && cur_v_ff && (tick_ff != 32'd0) &&
                  (status_ff[cur_ff] == ST_RUNNING) &&
                  (other_ready || (idle_ok && (mode_ff != MODE_COOP)));
   end

   // Memory commands.
   always_comb begin
      list_we    = 1'b0;
      list_waddr = len_ff[IW-1:0];
      list_wdata = add_slot;
      list_raddr = rd_idx_ff[IW-1:0];
      attr_wr    = '0;
      attr_raddr = list_rdata;
      case (state_ff)
         S_EXEC: begin
            case (act_ff)
               ACT_ADD, ACT_START: begin
                  if (add_ok && ((act_ff == ACT_ADD) || idle_present_ff)) begin
                     list_we         = 1'b1;
                     attr_wr.we      = 1'b1;
                     attr_wr.addr    = add_slot;
                     attr_wr.fld     = '{prio: 1'b1, chan: 1'b1, wake: 1'b1, quant: 1'b1};
                     attr_wr.data.prio  = (act_ff == ACT_ADD) ? pri_ff : 8'd0;
                     attr_wr.data.quant = quantum_ff;
                  end
               end
               ACT_BLOCK: begin
                  attr_wr.we        = cur_v_ff;
                  attr_wr.addr      = cur_ff;
                  attr_wr.fld.chan  = 1'b1;
                  attr_wr.data.chan = chan_ff;
               end
               ACT_SLEEP: begin
                  attr_wr.we        = cur_v_ff;
                  attr_wr.addr      = cur_ff;
                  attr_wr.fld.wake  = 1'b1;
                  attr_wr.data.wake = tick_ff + sleep_ff;
               end
               default: begin
               end
            endcase
         end
         S_QREAD: begin
            attr_raddr = cur_ff;
         end
         S_QDEC: begin
            attr_wr.we         = 1'b1;
            attr_wr.addr       = cur_ff;
            attr_wr.fld.quant  = 1'b1;
            attr_wr.data.quant = (q_dec == 8'd0) ? quantum_ff : q_dec;
         end
         S_SH_RD: begin
            list_raddr = j_plus[IW-1:0];
         end
         S_SH_WR: begin
            list_we    = 1'b1;
            list_waddr = j_ff[IW-1:0];
            list_wdata = list_rdata;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_COOP;
         idle_slot_ff    <= '0;
         idle_present_ff <= 1'b0;
         quantum_ff      <= QUANTUM_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_POLICY:       mode_ff         <= csr_wdata[1:0];
            CSR_IDLE_SLOT:    idle_slot_ff    <= csr_wdata[SLOT_W-1:0];
            CSR_IDLE_PRESENT: idle_present_ff <= csr_wdata[0];
            CSR_QUANTUM:      quantum_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         for (int s = 0; s < SLOT_COUNT; s++) begin
            status_ff[s] <= ST_FREE;
         end
         cur_ff       <= '0;
         cur_v_ff     <= 1'b0;
         tick_ff      <= '0;
         sw_cnt_ff    <= '0;
         idle_cnt_ff  <= '0;
         runnable_ff  <= '0;
         blocked_ff   <= '0;
         sleeping_ff  <= '0;
         active_ff    <= 1'b0;
         sw_ff        <= 1'b0;
         rd_idx_ff    <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         found_ff     <= 1'b0;
         run_cnt_ff   <= '0;
         aft_v_ff     <= 1'b0;
         bef_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff    <= req_action;
                  slot_ff   <= req_task_slot;
                  pri_ff    <= req_task_priority;
                  chan_ff   <= req_wait_channel_id;
                  sleep_ff  <= req_sleep_ticks;
                  run_en_ff <= req_run_enable;
                  sw_ff     <= 1'b0;
                  state_ff  <= S_EXEC;
               end
            end
            S_EXEC: begin
               rd_idx_ff  <= '0;
               s1_v_ff    <= 1'b0;
               s2_v_ff    <= 1'b0;
               found_ff   <= 1'b0;
               run_cnt_ff <= '0;
               aft_v_ff   <= 1'b0;
               bef_v_ff   <= 1'b0;
               key_ff     <= cur_ff;
               excl_ff    <= cur_v_ff;
               state_ff   <= S_SCAN;
               case (act_ff)
                  ACT_ADD: begin
                     if (add_ok) begin
                        len_ff             <= len_ff + LW'(1);
                        status_ff[slot_ff] <= ST_READY;
                     end
                     state_ff <= S_RESP;
                  end
                  ACT_REMOVE: begin
                     key_ff  <= slot_ff;
                     excl_ff <= 1'b1;
                  end
                  ACT_TICK: begin
                     tick_ff <= tick_ff + 32'd1;
                  end
                  ACT_YIELD: begin
                     if (!active_ff) begin
                        state_ff <= S_RESP;
                     end
                  end
                  ACT_BLOCK: begin
                     if (cur_v_ff) begin
                        if (status_ff[cur_ff] != ST_FREE) begin
                           status_ff[cur_ff] <= ST_BLOCKED;
                        end
                        if (blocked_ff < CNT_SAT) begin
                           blocked_ff <= blocked_ff + CNT_W'(1);
                        end
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
                  ACT_UNBLOCK: begin
                     excl_ff <= 1'b0;
                  end
                  ACT_SLEEP: begin
                     if (cur_v_ff) begin
                        if (status_ff[cur_ff] != ST_FREE) begin
                           status_ff[cur_ff] <= ST_SLEEPING;
                        end
                        if (sleeping_ff < CNT_SAT) begin
                           sleeping_ff <= sleeping_ff + CNT_W'(1);
                        end
                     end else begin
                        state_ff <= S_RESP;
                     end
                  end
                  ACT_SET_RUNNING: begin
                     active_ff <= run_en_ff;
                     state_ff  <= S_RESP;
                  end
                  ACT_START: begin
                     if (idle_present_ff && add_ok) begin
                        len_ff                  <= len_ff + LW'(1);
                        status_ff[idle_slot_ff] <= ST_READY;
                     end
                     active_ff <= 1'b1;
                     excl_ff   <= 1'b0;
                  end
                  default: begin
                     state_ff <= S_RESP;
                  end
               endcase
            end
            S_SCAN: begin
               if (rd_idx_ff < len_ff) begin
                  s1_v_ff   <= 1'b1;
                  s1_idx_ff <= rd_idx_ff[IW-1:0];
                  rd_idx_ff <= rd_idx_ff + LW'(1);
               end else begin
                  s1_v_ff <= 1'b0;
               end
               s2_v_ff    <= s1_v_ff;
               s2_slot_ff <= list_rdata;
               s2_idx_ff  <= s1_idx_ff;
               if (s2_v_ff) begin
                  if (e_woke) begin
                     status_ff[s2_slot_ff] <= ST_READY;
                     if (sleeping_ff != '0) begin
                        sleeping_ff <= sleeping_ff - CNT_W'(1);
                     end
                  end
                  if (e_unb) begin
                     status_ff[s2_slot_ff] <= ST_READY;
                     if (blocked_ff != '0) begin
                        blocked_ff <= blocked_ff - CNT_W'(1);
                     end
                  end
                  run_cnt_ff <= run_cnt_ff + CNT_W'(e_run);
                  if (e_key) begin
                     found_ff <= 1'b1;
                     pos_ff   <= s2_idx_ff;
                  end
                  if (take_aft) begin
                     aft_v_ff    <= 1'b1;
                     aft_slot_ff <= s2_slot_ff;
                     aft_pri_ff  <= attr_rdata.prio;
                  end
                  if (take_bef) begin
                     bef_v_ff    <= 1'b1;
                     bef_slot_ff <= s2_slot_ff;
                     bef_pri_ff  <= attr_rdata.prio;
                  end
               end
               if ((rd_idx_ff == len_ff) && !s1_v_ff && !s2_v_ff) begin
                  state_ff <= S_POST;
               end
            end
            S_POST: begin
               case (act_ff)
                  ACT_REMOVE: begin
                     j_ff     <= LW'(pos_ff);
                     state_ff <= found_ff ? S_SH_RD : S_RESP;
                  end
                  ACT_TICK: begin
                     runnable_ff <= run_cnt_ff;
                     if (mode_ff == MODE_COOP) begin
                        state_ff <= S_RESP;
                     end else if (quantum_cond) begin
                        state_ff <= S_QREAD;
                     end else begin
                        state_ff <= S_SCHED;
                     end
                  end
                  ACT_START: begin
                     if (pick_v) begin
                        if (cur_v_ff && (cur_ff != pick_slot) &&
                            (status_ff[cur_ff] == ST_RUNNING)) begin
                           status_ff[cur_ff] <= ST_READY;
                        end
                        sw_ff                <= !cur_v_ff || (cur_ff != pick_slot);
                        status_ff[pick_slot] <= ST_RUNNING;
                        cur_ff               <= pick_slot;
                        cur_v_ff             <= 1'b1;
                     end
                     state_ff <= S_RESP;
                  end
                  ACT_UNBLOCK: begin
                     state_ff <= S_RESP;
                  end
                  default: begin
                     state_ff <= S_SCHED;
                  end
               endcase
            end
            S_QREAD: begin
               state_ff <= S_QDEC;
            end
            S_QDEC: begin
               // The quantum is reloaded by the memory write when it runs out.
               state_ff <= (q_dec == 8'd0) ? S_SCHED : S_RESP;
            end
            S_SCHED: begin
               if (pick_v && !(cur_v_ff && (pick_slot == cur_ff))) begin
                  if (cur_v_ff && (status_ff[cur_ff] == ST_RUNNING)) begin
                     status_ff[cur_ff] <= ST_READY;
                  end
                  status_ff[pick_slot] <= ST_RUNNING;
                  cur_ff    <= pick_slot;
                  cur_v_ff  <= 1'b1;
                  sw_cnt_ff <= sw_cnt_ff + 32'd1;
                  if (idle_present_ff && (pick_slot == idle_slot_ff)) begin
                     idle_cnt_ff <= idle_cnt_ff + 32'd1;
                  end
                  sw_ff <= 1'b1;
               end
               state_ff <= S_RESP;
            end
            S_SH_RD: begin
               if (j_plus < len_ff) begin
                  state_ff <= S_SH_WR;
               end else begin
                  len_ff             <= len_ff - LW'(1);
                  status_ff[slot_ff] <= ST_FREE;
                  state_ff           <= S_RESP;
               end
            end
            S_SH_WR: begin
               j_ff     <= j_plus;
               state_ff <= S_SH_RD;
            end
            S_RESP: begin
               rsp_valid_ff <= 1'b1;
               rsp_cur_ff   <= cur_v_ff ? cur_ff : '0;
               rsp_cur_v_ff <= cur_v_ff;
               rsp_sw_ff    <= sw_ff;
               rsp_tick_ff  <= tick_ff;
               rsp_swc_ff   <= sw_cnt_ff;
               rsp_idlec_ff <= idle_cnt_ff;
               rsp_run_ff   <= runnable_ff;
               rsp_blk_ff   <= blocked_ff;
               rsp_slp_ff   <= sleeping_ff;
               rsp_cs_ff    <= can_sleep;
               rsp_act_ff   <= active_ff;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy                  = (state_ff != S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_current_slot      = rsp_cur_ff;
   assign rsp_current_valid     = rsp_cur_v_ff;
   assign rsp_switched          = rsp_sw_ff;
   assign rsp_tick_total        = rsp_tick_ff;
   assign rsp_switch_total      = rsp_swc_ff;
   assign rsp_idle_switch_total = rsp_idlec_ff;
   assign rsp_runnable_total    = rsp_run_ff;
   assign rsp_blocked_total     = rsp_blk_ff;
   assign rsp_sleeping_total    = rsp_slp_ff;
   assign rsp_can_sleep_now     = rsp_cs_ff;
   assign rsp_running_flag      = rsp_act_ff;

endmodule

/* tb/sv/task_run_queue_scheduler_tb.sv */
// ----------------------------------------------------------------------------
// Task run queue scheduler testbench
// Drives scheduler event requests through the start/busy handshake and checks
// every result against an in-bench model of the run list, statuses, counters
// and selection policy, over several register settings and idle patterns.
// ----------------------------------------------------------------------------
module task_run_queue_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import trq_pkg::*;

   // Policy code 3 behaves as preemptive round robin.
   localparam logic [1:0] MODE_RR_ALT = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         DRAIN_WAIT  = 100;

   typedef struct {
      logic [3:0]  action;
      logic [3:0]  slot;
      logic [7:0]  prio;
      logic [15:0] chan;
      logic [31:0] ticks;
      logic        run_en;
   } sched_req_type;

   typedef struct {
      logic [3:0]  cur_slot;
      logic        cur_valid;
      logic        switched;
      logic [31:0] ticks;
      logic [31:0] switches;
      logic [31:0] idle_switches;
      logic [4:0]  runnable;
      logic [4:0]  blocked;
      logic [4:0]  sleeping;
      logic        can_sleep;
      logic        running;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_action = '0;
   logic [3:0]  req_task_slot = '0;
   logic [7:0]  req_task_priority = '0;
   logic [15:0] req_wait_channel_id = '0;
   logic [31:0] req_sleep_ticks = '0;
   logic        req_run_enable = 1'b0;
   logic        rsp_valid;
   logic [3:0]  rsp_current_slot;
   logic        rsp_current_valid;
   logic        rsp_switched;
   logic [31:0] rsp_tick_total;
   logic [31:0] rsp_switch_total;
   logic [31:0] rsp_idle_switch_total;
   logic [4:0]  rsp_runnable_total;
   logic [4:0]  rsp_blocked_total;
   logic [4:0]  rsp_sleeping_total;
   logic        rsp_can_sleep_now;
   logic        rsp_running_flag;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [7:0]  csr_wdata = '0;

   task_run_queue_scheduler dut (.*);

   always #4 clock = ~clock;

   sched_req_type pending_reqs[$];
   sched_rsp_type expected_rsps[$];
   int         gap_pct = 0;
   int         errors = 0;
   int         cycles = 0;
   bit         taken = 0;

   // Scheduler state mirrored by the predictor.
   logic [1:0]  cfg_mode = MODE_COOP;
   logic [3:0]  cfg_idle_slot = '0;
   logic        cfg_idle_present = 1'b0;
   logic [7:0]  cfg_quantum = QUANTUM_RESET;
   logic [3:0]  run_list [16];
   int          list_len = 0;
   status_type  slot_sts [16];
   logic [7:0]  slot_pri [16];
   logic [15:0] slot_chan [16];
   logic [31:0] slot_wake [16];
   logic [7:0]  slot_quant [16];
   logic        cur_valid = 1'b0;
   logic [3:0]  cur_slot = '0;
   logic [31:0] tick_cnt = '0, switch_cnt = '0, idle_cnt = '0;
   int          runnable_cnt = 0, blocked_cnt = 0, sleeping_cnt = 0;
   logic        active = 1'b0;

   initial begin
      for (int i = 0; i < 16; i++) begin
         slot_sts[i] = ST_FREE;
         run_list[i] = '0;
      end
   end

   function automatic int list_pos(logic [3:0] s);
      for (int i = 0; i < list_len; i++)
         if (run_list[i] == s) return i;
      return list_len;
   endfunction

   function automatic int idle_choice();
      if (cfg_idle_present && slot_sts[cfg_idle_slot] != ST_FREE) return int'(cfg_idle_slot);
      return -1;
   endfunction

   // Scans the list after position p, wrapping round; p equal to the length
   // means the whole list is scanned from the front.
   function automatic int pick_next(int p);
      int best = -1;
      int n = list_len;
      int cnt = (p < n) ? n - 1 : n;
      int first = (p < n) ? p + 1 : 0;
      logic [3:0] s;
      for (int j = 0; j < cnt; j++) begin
         s = run_list[(first + j) % n];
         if (slot_sts[s] == ST_READY) begin
            if (cfg_mode != MODE_PRIO) return int'(s);
            if (best < 0 || slot_pri[s] > slot_pri[best]) best = int'(s);
         end
      end
      return (best >= 0) ? best : idle_choice();
   endfunction

   function automatic bit reschedule();
      int nxt = pick_next(cur_valid ? list_pos(cur_slot) : list_len);
      if (nxt < 0 || (cur_valid && nxt == cur_slot)) return 0;
      if (cur_valid && slot_sts[cur_slot] == ST_RUNNING) slot_sts[cur_slot] = ST_READY;
      slot_sts[nxt] = ST_RUNNING;
      cur_slot = 4'(nxt);
      cur_valid = 1'b1;
      switch_cnt++;
      if (cfg_idle_present && nxt == cfg_idle_slot) idle_cnt++;
      return 1;
   endfunction

   function automatic void list_add(logic [3:0] s, logic [7:0] p);
      if (slot_sts[s] != ST_FREE || list_len >= 16) return;
      run_list[list_len] = s;
      list_len++;
      slot_sts[s] = ST_READY;
      slot_pri[s] = p;
      slot_chan[s] = '0;
      slot_wake[s] = '0;
      slot_quant[s] = cfg_quantum;
   endfunction

   function automatic void list_remove(logic [3:0] s);
      int p = list_pos(s);
      if (p >= list_len) return;
      for (int i = p; i + 1 < list_len; i++) run_list[i] = run_list[i + 1];
      list_len--;
      slot_sts[s] = ST_FREE;
   endfunction

   function automatic bit clock_tick();
      logic [3:0] s;
      int run = 0;
      tick_cnt++;
      for (int i = 0; i < list_len; i++) begin
         s = run_list[i];
         if (slot_sts[s] == ST_SLEEPING && slot_wake[s] <= tick_cnt) begin
            slot_sts[s] = ST_READY;
            slot_wake[s] = '0;
            if (sleeping_cnt > 0) sleeping_cnt--;
         end
      end
      for (int i = 0; i < list_len; i++)
         if (slot_sts[run_list[i]] inside {ST_READY, ST_RUNNING}) run++;
      runnable_cnt = run;
      if (cfg_mode == MODE_COOP) return 0;
      if (cur_valid && slot_sts[cur_slot] == ST_RUNNING &&
          !(cfg_idle_present && cur_slot == cfg_idle_slot)) begin
         if (slot_quant[cur_slot] > 0) slot_quant[cur_slot]--;
         if (slot_quant[cur_slot] == 0) begin
            slot_quant[cur_slot] = cfg_quantum;
            return reschedule();
         end
         return 0;
      end
      return reschedule();
   endfunction

   function automatic bit sleep_allowed();
      if (!active || !cur_valid || tick_cnt == 0 || slot_sts[cur_slot] != ST_RUNNING)
         return 0;
      for (int i = 0; i < list_len; i++)
         if (run_list[i] != cur_slot && slot_sts[run_list[i]] == ST_READY) return 1;
      return idle_choice() >= 0 && cfg_mode != MODE_COOP;
   endfunction

   function automatic sched_rsp_type predict_event(sched_req_type r);
      sched_rsp_type o;
      bit sw = 0;
      int first;
      case (r.action)
         ACT_ADD:    list_add(r.slot, r.prio);
         ACT_REMOVE: list_remove(r.slot);
         ACT_TICK:   sw = clock_tick();
         ACT_YIELD:  if (active) sw = reschedule();
         ACT_BLOCK: begin
            if (cur_valid) begin
               if (slot_sts[cur_slot] != ST_FREE) slot_sts[cur_slot] = ST_BLOCKED;
               slot_chan[cur_slot] = r.chan;
               if (blocked_cnt < 16) blocked_cnt++;
               sw = reschedule();
            end
         end
         ACT_UNBLOCK: begin
            for (int i = 0; i < list_len; i++) begin
               if (slot_sts[run_list[i]] == ST_BLOCKED && slot_chan[run_list[i]] == r.chan) begin
                  slot_sts[run_list[i]] = ST_READY;
                  slot_chan[run_list[i]] = '0;
                  if (blocked_cnt > 0) blocked_cnt--;
               end
            end
         end
         ACT_SLEEP: begin
            if (cur_valid) begin
               if (slot_sts[cur_slot] != ST_FREE) slot_sts[cur_slot] = ST_SLEEPING;
               slot_wake[cur_slot] = tick_cnt + r.ticks;
               if (sleeping_cnt < 16) sleeping_cnt++;
               sw = reschedule();
            end
         end
         ACT_SET_RUNNING: active = r.run_en;
         ACT_START: begin
            if (cfg_idle_present) list_add(cfg_idle_slot, 8'd0);
            active = 1'b1;
            first = pick_next(list_len);
            if (first >= 0) begin
               if (cur_valid && cur_slot != first && slot_sts[cur_slot] == ST_RUNNING)
                  slot_sts[cur_slot] = ST_READY;
               if (!cur_valid || cur_slot != first) sw = 1;
               slot_sts[first] = ST_RUNNING;
               cur_slot = 4'(first);
               cur_valid = 1'b1;
            end
         end
         default: ;
      endcase
      o.cur_slot      = cur_valid ? cur_slot : 4'd0;
      o.cur_valid     = cur_valid;
      o.switched      = sw;
      o.ticks         = tick_cnt;
      o.switches      = switch_cnt;
      o.idle_switches = idle_cnt;
      o.runnable      = runnable_cnt[4:0];
      o.blocked       = blocked_cnt[4:0];
      o.sleeping      = sleeping_cnt[4:0];
      o.can_sleep     = sleep_allowed();
      o.running       = active;
      return o;
   endfunction

   // Request driver: holds a request until it is taken, then moves on.
   always @(negedge clock) begin
      sched_req_type r;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         taken = 0;
         if (pending_reqs.size() > 0 && $urandom_range(99) >= gap_pct) begin
            r = pending_reqs.pop_front();
            start               <= 1'b1;
            req_action          <= r.action;
            req_task_slot       <= r.slot;
            req_task_priority   <= r.prio;
            req_wait_channel_id <= r.chan;
            req_sleep_ticks     <= r.ticks;
            req_run_enable      <= r.run_en;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
         errors++;
      end
   endtask

   // Monitor: checks results first, then predicts the request taken at this edge.
   always @(posedge clock) begin
      sched_rsp_type e;
      sched_req_type r;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         if (csr_we) begin
            case (csr_addr)
               CSR_POLICY:       cfg_mode = csr_wdata[1:0];
               CSR_IDLE_SLOT:    cfg_idle_slot = csr_wdata[3:0];
               CSR_IDLE_PRESENT: cfg_idle_present = csr_wdata[0];
               CSR_QUANTUM:      cfg_quantum = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               $error("result with no request outstanding");
               errors++;
            end else begin
               e = expected_rsps.pop_front();
               check_field("current_slot", 32'(e.cur_slot), 32'(rsp_current_slot));
               check_field("current_valid", 32'(e.cur_valid), 32'(rsp_current_valid));
               check_field("switched", 32'(e.switched), 32'(rsp_switched));
               check_field("tick_total", e.ticks, rsp_tick_total);
               check_field("switch_total", e.switches, rsp_switch_total);
               check_field("idle_switch_total", e.idle_switches, rsp_idle_switch_total);
               check_field("runnable_total", 32'(e.runnable), 32'(rsp_runnable_total));
               check_field("blocked_total", 32'(e.blocked), 32'(rsp_blocked_total));
               check_field("sleeping_total", 32'(e.sleeping), 32'(rsp_sleeping_total));
               check_field("can_sleep_now", 32'(e.can_sleep), 32'(rsp_can_sleep_now));
               check_field("running_flag", 32'(e.running), 32'(rsp_running_flag));
            end
         end
         if (start && !busy) begin
            r.action = req_action;
            r.slot   = req_task_slot;
            r.prio   = req_task_priority;
            r.chan   = req_wait_channel_id;
            r.ticks  = req_sleep_ticks;
            r.run_en = req_run_enable;
            expected_rsps.push_back(predict_event(r));
            taken = 1;
         end
      end
   end

   function automatic sched_req_type make_req(logic [3:0] a, logic [3:0] s = 0,
                                              logic [7:0] p = 0, logic [15:0] c = 0,
                                              logic [31:0] t = 0, logic en = 0);
      sched_req_type r;
      r.action = a; r.slot = s; r.prio = p; r.chan = c; r.ticks = t; r.run_en = en;
      return r;
   endfunction

   function automatic sched_req_type random_req();
      sched_req_type r;
      int w = $urandom_range(99);
      r.slot   = 4'($urandom_range(15));
      r.prio   = 8'($urandom_range(255));
      // Channels mostly come from a small set so that unblocks find waiters.
      r.chan   = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      r.ticks  = ($urandom_range(15) == 0) ? $urandom : 32'($urandom_range(6));
      r.run_en = ($urandom_range(3) != 0);
      if      (w < 15) r.action = ACT_ADD;
      else if (w < 22) r.action = ACT_REMOVE;
      else if (w < 52) r.action = ACT_TICK;
      else if (w < 62) r.action = ACT_YIELD;
      else if (w < 70) r.action = ACT_BLOCK;
      else if (w < 78) r.action = ACT_UNBLOCK;
      else if (w < 86) r.action = ACT_SLEEP;
      else if (w < 90) r.action = ACT_SET_RUNNING;
      else if (w < 96) r.action = ACT_START;
      else             r.action = 4'($urandom_range(15, 9));
      return r;
   endfunction

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [7:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic run_phase(logic [1:0] mode, logic [3:0] idle_s, logic idle_p,
                            logic [7:0] quantum, int gap);
      wait_idle();
      write_reg(CSR_POLICY, {6'd0, mode});
      write_reg(CSR_IDLE_SLOT, {4'd0, idle_s});
      write_reg(CSR_IDLE_PRESENT, {7'd0, idle_p});
      write_reg(CSR_QUANTUM, quantum);
      gap_pct = gap;
      for (int i = 0; i < 150; i++) pending_reqs.push_back(random_req());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests under the reset settings.
      pending_reqs.push_back(make_req(ACT_START));
      pending_reqs.push_back(make_req(ACT_TICK));
      pending_reqs.push_back(make_req(ACT_YIELD));
      pending_reqs.push_back(make_req(ACT_BLOCK, 0, 0, 16'hFFFF));
      pending_reqs.push_back(make_req(ACT_SLEEP, 0, 0, 0, 32'd3));
      pending_reqs.push_back(make_req(ACT_ADD, 4'd15, 8'd255));
      pending_reqs.push_back(make_req(ACT_ADD, 4'd0, 8'd0));
      pending_reqs.push_back(make_req(ACT_ADD, 4'd15, 8'd7));
      pending_reqs.push_back(make_req(ACT_START));
      pending_reqs.push_back(make_req(ACT_TICK));
      pending_reqs.push_back(make_req(ACT_SLEEP, 0, 0, 0, 32'd1));
      pending_reqs.push_back(make_req(ACT_TICK));
      pending_reqs.push_back(make_req(ACT_TICK));
      pending_reqs.push_back(make_req(ACT_BLOCK, 0, 0, 16'hFFFF));
      pending_reqs.push_back(make_req(ACT_UNBLOCK, 0, 0, 16'hFFFF));
      pending_reqs.push_back(make_req(ACT_SLEEP, 0, 0, 0, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(ACT_YIELD));
      pending_reqs.push_back(make_req(ACT_REMOVE, 4'd15));
      pending_reqs.push_back(make_req(ACT_REMOVE, 4'd9));
      pending_reqs.push_back(make_req(ACT_SET_RUNNING, 0, 0, 0, 0, 1'b0));
      pending_reqs.push_back(make_req(ACT_YIELD));
      pending_reqs.push_back(make_req(ACT_SET_RUNNING, 0, 0, 0, 0, 1'b1));
      pending_reqs.push_back(make_req(4'd9));
      pending_reqs.push_back(make_req(4'd15));

      run_phase(MODE_RR, 4'd3, 1'b1, 8'd1, 0);
      run_phase(MODE_PRIO, 4'd15, 1'b1, 8'd255, 82);
      run_phase(MODE_COOP, 4'd0, 1'b1, 8'd2, 11);
      run_phase(MODE_RR_ALT, 4'd7, 1'b0, 8'd0, 0);
      run_phase(MODE_PRIO, 4'd0, 1'b1, 8'd3, 82);
      run_phase(MODE_RR, 4'd15, 1'b0, 8'd5, 11);
      wait_idle();

      if (expected_rsps.size() != 0) begin
         $error("%0d results never arrived", expected_rsps.size());
         errors++;
      end
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* sim.f */
src/trq_pkg.sv
src/trq_list_ram.sv
src/trq_attr_ram.sv
src/task_run_queue_scheduler.sv
tb/sv/task_run_queue_scheduler_tb.sv
